/* src/kssb_pkg.sv */
// kssb_pkg: shared constants, types and helpers for the shared-buffer stack block.
// No dependencies; imported by kssb_slot_store and k_stacks_shared_buffer.
`default_nettype none

package kssb_pkg;

  localparam int NUM_STACKS = 4;
  localparam int DEPTH      = 32;
  localparam int PTR_W      = $clog2(DEPTH + 1);  // slot number or null
  localparam int ADDR_W     = $clog2(DEPTH);      // memory address
  localparam int DATA_W     = 32;
  localparam int CNT_W      = 6;
  localparam int CMD_W      = 2;
  localparam int SID_W      = 2;

  // Null pointer is coded as DEPTH.
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Write request into the slot store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
    logic [PTR_W-1:0]  link;
  } slot_wr_t;

  function automatic logic is_null(input logic [PTR_W-1:0] p);
    return (p >= NULL_PTR);
  endfunction

  // Map any out-of-range pointer to null.
  function automatic logic [PTR_W-1:0] sane_ptr(input logic [PTR_W-1:0] p);
    return is_null(p) ? NULL_PTR : p;
  endfunction

endpackage

`default_nettype wire

/* src/kssb_slot_store.sv */
// kssb_slot_store: slot memories (value and link below) with one write and one read port.
// Read data is registered. Depends on kssb_pkg.
`default_nettype none

module kssb_slot_store
  import kssb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire slot_wr_t          wr,
  output logic [DATA_W-1:0]      rd_value,
  output logic [PTR_W-1:0]       rd_link
);

  logic [DATA_W-1:0] slot_values [DEPTH];
  logic [PTR_W-1:0]  slot_links  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      slot_values[wr.addr] <= wr.value;
      slot_links[wr.addr]  <= wr.link;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_value <= slot_values[rd_addr];
      rd_link  <= slot_links[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/k_stacks_shared_buffer.sv */
// k_stacks_shared_buffer: four LIFO stacks sharing a 32-slot store with a linked free list.
// Result: the item is captured at the accepting edge and its result is loaded into the output
//   register when it executes, later while an earlier result waits there under stall.
// A new item is taken only once the last one has executed; memories are read at the accept
//   edge and written back when the item executes. Input is stalled during reset.
// Reset: synchronous; stacks empty, free list in slot order. Free-list entries carry valid
//   bits, so there is no clearing pass. Depends on kssb_pkg, kssb_slot_store.
`default_nettype none

module k_stacks_shared_buffer
  import kssb_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // input channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [CMD_W-1:0]         command,
  input  wire logic [SID_W-1:0]         stack_id,
  input  wire logic signed [DATA_W-1:0] push_value,
  // output channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      data_out,
  output logic                          empty_flag,
  output logic                          full_flag,
  output logic [CNT_W-1:0]              total_count
);

  // ---------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------
  state_t state, state_next;
  logic   in_fire;
  logic   exec_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid)  state_next = ST_EXEC;
      ST_EXEC: if (exec_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Take an item only when idle and out of reset; execute once the output register is free.
  always_comb begin
    in_stall  = 1'b1;
    exec_fire = 1'b0;
    case (state)
      ST_IDLE: in_stall  = rst;
      ST_EXEC: exec_fire = !out_valid || !out_stall;
      default: ;
    endcase
  end

  assign in_fire = in_valid && !in_stall;

  // ---------------------------------------------------------------
  // Architectural registers
  // ---------------------------------------------------------------
  logic [PTR_W-1:0] stack_tops [NUM_STACKS];
  logic [PTR_W-1:0] free_head;
  logic [CNT_W-1:0] entry_count;

  // Item captured at accept
  cmd_t              cmd_q;
  logic [SID_W-1:0]  sid_q;
  logic              sid_ok_q;
  logic [DATA_W-1:0] val_q;
  logic [PTR_W-1:0]  top_q;

  logic             sid_ok;
  logic [PTR_W-1:0] top_sel;

  assign sid_ok  = (int'(stack_id) < NUM_STACKS);
  assign top_sel = sid_ok ? sane_ptr(stack_tops[stack_id]) : NULL_PTR;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q    <= cmd_t'(command);
      sid_q    <= stack_id;
      sid_ok_q <= sid_ok;
      val_q    <= push_value;
      top_q    <= top_sel;
    end
  end

  // ---------------------------------------------------------------
  // Slot store: read the top slot on accept, write a pushed slot on execute
  // ---------------------------------------------------------------
  slot_wr_t          slot_wr;
  logic [DATA_W-1:0] slot_rd_value;
  logic [PTR_W-1:0]  slot_rd_link;

  kssb_slot_store u_slot_store (
    .clk      (clk),
    .rd_en    (in_fire),
    .rd_addr  (top_sel[ADDR_W-1:0]),
    .wr       (slot_wr),
    .rd_value (slot_rd_value),
    .rd_link  (slot_rd_link)
  );

  // ---------------------------------------------------------------
  // Free list: memory plus one valid bit per entry; an entry never
  // written reads as its reset link, slot i -> i+1 (last one -> null).
  // ---------------------------------------------------------------
  logic [PTR_W-1:0]  free_links [DEPTH];
  logic [DEPTH-1:0]  fl_vld;
  logic [PTR_W-1:0]  fl_rd_q;
  logic              fl_hit_q;
  logic              fl_we;
  logic [ADDR_W-1:0] fl_waddr;
  logic [PTR_W-1:0]  fl_wdata;
  logic [PTR_W-1:0]  fl_next;

  always_ff @(posedge clk) begin
    if (fl_we) begin
      free_links[fl_waddr] <= fl_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fl_rd_q  <= free_links[free_head[ADDR_W-1:0]];
      fl_hit_q <= fl_vld[free_head[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fl_vld <= '0;
    end else if (fl_we) begin
      fl_vld[fl_waddr] <= 1'b1;
    end
  end

  // Successor of the current free head; free_head holds still until execute.
  assign fl_next = sane_ptr(fl_hit_q ? fl_rd_q : free_head + PTR_W'(1));

  // ---------------------------------------------------------------
  // Execute: modify and write back
  // ---------------------------------------------------------------
  logic [PTR_W-1:0]  free_head_next;
  logic [CNT_W-1:0]  entry_count_next;
  logic              top_we;
  logic [PTR_W-1:0]  top_wdata;
  logic [DATA_W-1:0] res_data;
  logic              res_empty;
  logic              res_full;

  always_comb begin
    free_head_next   = free_head;
    entry_count_next = entry_count;
    top_we           = 1'b0;
    top_wdata        = top_q;
    fl_we            = 1'b0;
    fl_waddr         = top_q[ADDR_W-1:0];
    fl_wdata         = sane_ptr(free_head);
    slot_wr.en       = 1'b0;
    slot_wr.addr     = free_head[ADDR_W-1:0];
    slot_wr.value    = val_q;
    slot_wr.link     = top_q;
    res_data         = '0;
    res_empty        = 1'b0;
    res_full         = 1'b0;
    case (cmd_q)
      CMD_PUSH: begin
        if (!sid_ok_q || is_null(free_head)) begin
          res_full = 1'b1;
        end else begin
          // take the free head, link it above the old top
          slot_wr.en       = exec_fire;
          free_head_next   = fl_next;
          top_we           = 1'b1;
          top_wdata        = free_head;
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (is_null(top_q)) begin
          res_empty = 1'b1;
        end else begin
          res_data = slot_rd_value;
          if (cmd_q == CMD_POP) begin
            // unlink the top and return its slot to the free list
            top_we         = 1'b1;
            top_wdata      = sane_ptr(slot_rd_link);
            fl_we          = exec_fire;
            free_head_next = top_q;
            if (entry_count != '0) begin
              entry_count_next = entry_count - CNT_W'(1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_tops[i] <= NULL_PTR;
      end
      free_head   <= '0;
      entry_count <= '0;
    end else if (exec_fire) begin
      if (top_we) begin
        stack_tops[sid_q] <= top_wdata;
      end
      free_head   <= free_head_next;
      entry_count <= entry_count_next;
    end
  end

  // ---------------------------------------------------------------
  // Output register: load on execute, drop once taken
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      data_out    <= res_data;
      empty_flag  <= res_empty;
      full_flag   <= res_full;
      total_count <= entry_count_next;
    end
  end

endmodule

`default_nettype wire
